// ===== hw/rtl/gebp_pkg.sv =====
// Shared types and constants for the Golomb encoder and bit packer.
// Used by gebp_datapath, gebp_ctrl and golomb_encoder_bit_packer_top.
`default_nettype none

package gebp_pkg;

  // Packed output word width
  localparam int WORD_W = 32;
  // Divisor register width and the saturation point of code_bits
  localparam int DIV_W  = 16;
  localparam int CB_W   = 5;
  localparam int CB_MAX = 16;
  // Pending bits plus the new code must stay below this many bits
  localparam int MAX_WORDS  = 3;
  localparam int CODE_LIMIT = (MAX_WORDS + 1) * WORD_W;

  // Configuration register indexes
  localparam logic CFG_DIVISOR   = 1'b0;
  localparam logic CFG_CODE_BITS = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic div_start;   // latch value and start the divider
    logic prep;        // register saturated b and threshold
    logic check;       // register code fields and word count
    logic app_ones;    // append a chunk of unary ones
    logic app_tail;    // append stop bit and remainder field
    logic emit_word;   // move a full word to the output register
    logic emit_flush;  // move leftover bits to the output register
    logic emit_err;    // load an error result
  } gebp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_done;
    logic divisor_zero;
    logic bad;
    logic ones_nz;
    logic word_full;
    logic pend_nz;
    logic out_free;
  } gebp_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/gebp_divider.sv =====
// Restoring divider, one quotient bit per cycle.
// Standalone; instantiated by gebp_datapath.
`default_nettype none

module gebp_divider #(
  parameter int VALUE_BITS = 16,
  parameter int DIV_W      = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [VALUE_BITS-1:0] dividend_i,
  input  wire logic [DIV_W-1:0]      divisor_i,
  output logic                       done_o,
  output logic [VALUE_BITS-1:0]      quot_o,
  output logic [DIV_W-1:0]           rem_o
);

  localparam int CntW = $clog2(VALUE_BITS + 1);
  localparam logic [CntW-1:0] Steps = CntW'(VALUE_BITS);

  logic                  busy_q;
  logic [CntW-1:0]       cnt_q;
  logic [VALUE_BITS-1:0] quot_q;
  logic [DIV_W-1:0]      rem_q;

  logic [DIV_W:0] trial;
  logic [DIV_W:0] diff;
  logic           fits;

  // one restoring step
  assign trial = {rem_q, quot_q[VALUE_BITS-1]};
  assign diff  = trial - {1'b0, divisor_i};
  assign fits  = (trial >= {1'b0, divisor_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= Steps;
    end else if (busy_q) begin
      cnt_q <= cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
    end else if (busy_q) begin
      quot_q <= {quot_q[VALUE_BITS-2:0], fits};
      rem_q  <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
    end
  end

  assign done_o = !busy_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// ===== hw/rtl/gebp_datapath.sv =====
// Datapath: configuration registers, divider, code field logic,
// left-aligned bit accumulator and output register. Uses gebp_pkg, gebp_divider.
`default_nettype none

module gebp_datapath #(
  parameter int VALUE_BITS   = 16,
  parameter int MAX_QUOTIENT = 62
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // configuration
  input  wire logic                   cfg_we_i,
  input  wire logic                   cfg_idx_i,
  input  wire logic [gebp_pkg::DIV_W-1:0] cfg_wdata_i,
  // item payload
  input  wire logic [VALUE_BITS-1:0]  value_i,
  // control
  input  wire gebp_pkg::gebp_cmd_t    cmd_i,
  output gebp_pkg::gebp_status_t      status_o,
  // result
  input  wire logic                   out_ready_i,
  output logic                        out_valid_o,
  output logic [gebp_pkg::WORD_W-1:0] out_code_word_o,
  output logic [5:0]                  out_bit_count_o,
  output logic                        out_last_o,
  output logic                        out_error_o
);

  localparam int WW   = gebp_pkg::WORD_W;
  localparam int DW   = gebp_pkg::DIV_W;
  localparam int QW   = $clog2(MAX_QUOTIENT + 1);
  localparam int SumW = $clog2(MAX_QUOTIENT + 178);
  localparam logic [VALUE_BITS-1:0] MaxQ  = VALUE_BITS'(MAX_QUOTIENT);
  localparam logic [SumW-1:0]       Limit = SumW'(gebp_pkg::CODE_LIMIT);

  // configuration registers
  logic [DW-1:0]               divisor_q;
  logic [gebp_pkg::CB_W-1:0]   code_bits_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      divisor_q   <= DW'(8);
      code_bits_q <= gebp_pkg::CB_W'(3);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gebp_pkg::CFG_DIVISOR:   divisor_q   <= cfg_wdata_i;
        gebp_pkg::CFG_CODE_BITS: code_bits_q <= cfg_wdata_i[gebp_pkg::CB_W-1:0];
        default: ;
      endcase
    end
  end

  // divider
  logic                  div_done;
  logic [VALUE_BITS-1:0] quot;
  logic [DW-1:0]         rem;

  gebp_divider #(
    .VALUE_BITS(VALUE_BITS),
    .DIV_W     (DW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .dividend_i(value_i),
    .divisor_i (divisor_q),
    .done_o    (div_done),
    .quot_o    (quot),
    .rem_o     (rem)
  );

  // first stage of the remainder code: saturated b and T = 2^b - M
  logic [4:0]    bsat;
  logic [DW:0]   pow2;
  logic [DW+1:0] tdiff;
  logic [4:0]    bsat_q;
  logic [DW-1:0] thr_q;

  assign bsat  = (code_bits_q > 5'(gebp_pkg::CB_MAX)) ? 5'(gebp_pkg::CB_MAX) : code_bits_q;
  assign pow2  = (DW+1)'(1) << bsat;
  assign tdiff = {1'b0, pow2} - {2'b0, divisor_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      bsat_q <= bsat;
      thr_q  <= tdiff[DW+1] ? '0 : tdiff[DW-1:0];
    end
  end

  // second stage: field length, field value, reject test, word count
  logic          short_form;
  logic [4:0]    tlen;
  logic [DW:0]   tsum;
  logic [DW-1:0] tmask;
  logic [DW-1:0] tval;
  logic [SumW-1:0] code_sum;
  logic          q_big;

  // short form sends the remainder itself, long form remainder plus T
  assign short_form = (rem < thr_q);
  assign tlen  = short_form ? (bsat_q - 5'd1) : bsat_q;
  assign tsum  = short_form ? {1'b0, rem} : ({1'b0, rem} + {1'b0, thr_q});
  assign tmask = ~({DW{1'b1}} << tlen);
  assign tval  = tsum[DW-1:0] & tmask;
  assign q_big = (quot > MaxQ);

  // accumulator: pending bits left-aligned at the top, zeros below
  logic [2*WW-1:0] acc_q;
  logic [5:0]      cnt_q;
  logic [QW-1:0]   ones_q;
  logic [4:0]      tlen_q;
  logic [DW-1:0]   tval_q;
  logic [1:0]      total_q;
  logic [1:0]      sent_q;

  assign code_sum = SumW'(cnt_q) + SumW'(quot[QW-1:0]) + SumW'(1) + SumW'(tlen);

  // chunk to append, left-aligned in a word
  logic [5:0]    ones_k;
  logic [5:0]    tail_len;
  logic [WW-1:0] chunk;
  logic [5:0]    chunk_len;
  logic [2*WW-1:0] chunk_pos;

  assign ones_k   = (32'(ones_q) > 32'(WW)) ? 6'(WW) : 6'(ones_q);
  assign tail_len = 6'(tlen_q) + 6'd1;

  always_comb begin
    if (cmd_i.app_tail) begin
      chunk     = (WW'(tval_q)) << (6'(WW) - tail_len);
      chunk_len = tail_len;
    end else begin
      chunk     = ~({WW{1'b1}} >> ones_k);
      chunk_len = ones_k;
    end
  end

  assign chunk_pos = {chunk, {WW{1'b0}}} >> cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      cnt_q <= '0;
    end else if (cmd_i.app_ones || cmd_i.app_tail) begin
      acc_q <= acc_q | chunk_pos;
      cnt_q <= cnt_q + chunk_len;
    end else if (cmd_i.emit_word) begin
      acc_q <= {acc_q[WW-1:0], {WW{1'b0}}};
      cnt_q <= cnt_q - 6'(WW);
    end else if (cmd_i.emit_flush) begin
      acc_q <= '0;
      cnt_q <= '0;
    end
  end

  // per-item code fields and word bookkeeping
  always_ff @(posedge clk_i) begin
    if (cmd_i.check) begin
      ones_q  <= quot[QW-1:0];
      tlen_q  <= tlen;
      tval_q  <= tval;
      total_q <= code_sum[6:5];
      sent_q  <= '0;
    end else begin
      if (cmd_i.app_ones) begin
        ones_q <= ones_q - QW'(ones_k);
      end
      if (cmd_i.emit_word) begin
        sent_q <= sent_q + 2'd1;
      end
    end
  end

  // output register
  logic            out_valid_q;
  logic [WW-1:0]   out_word_q;
  logic [5:0]      out_count_q;
  logic            out_last_q;
  logic            out_error_q;
  logic            out_free;
  logic            load;

  assign out_free = !out_valid_q || out_ready_i;
  assign load     = cmd_i.emit_word || cmd_i.emit_flush || cmd_i.emit_err;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_word) begin
      out_word_q  <= acc_q[2*WW-1:WW];
      out_count_q <= 6'(WW);
      out_last_q  <= ({1'b0, sent_q} + 3'd1 == {1'b0, total_q});
      out_error_q <= 1'b0;
    end else if (cmd_i.emit_flush) begin
      out_word_q  <= acc_q[2*WW-1:WW];
      out_count_q <= cnt_q;
      out_last_q  <= 1'b1;
      out_error_q <= 1'b0;
    end else if (cmd_i.emit_err) begin
      out_word_q  <= '0;
      out_count_q <= '0;
      out_last_q  <= 1'b1;
      out_error_q <= 1'b1;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_code_word_o = out_word_q;
  assign out_bit_count_o = out_count_q;
  assign out_last_o      = out_last_q;
  assign out_error_o     = out_error_q;

  // status to the controller
  always_comb begin
    status_o.div_done     = div_done;
    status_o.divisor_zero = (divisor_q == '0);
    status_o.bad          = q_big || (code_sum >= Limit);
    status_o.ones_nz      = (ones_q != '0);
    status_o.word_full    = (cnt_q >= 6'(WW));
    status_o.pend_nz      = (cnt_q != '0);
    status_o.out_free     = out_free;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/gebp_ctrl.sv =====
// Controller state machine: sequences division, code checks, appends and
// word output. Uses gebp_pkg; drives gebp_datapath through command signals.
`default_nettype none

module gebp_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  input  wire logic                   in_kind_i,
  output logic                        in_ready_o,
  input  wire gebp_pkg::gebp_status_t status_i,
  output gebp_pkg::gebp_cmd_t         cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DIV    = 4'd1;
  localparam logic [3:0] S_PREP   = 4'd2;
  localparam logic [3:0] S_CHECK  = 4'd3;
  localparam logic [3:0] S_ONES   = 4'd4;
  localparam logic [3:0] S_WORD_O = 4'd5;
  localparam logic [3:0] S_TAIL   = 4'd6;
  localparam logic [3:0] S_WORD_T = 4'd7;
  localparam logic [3:0] S_FLUSH  = 4'd8;
  localparam logic [3:0] S_ERR    = 4'd9;

  localparam logic KIND_FLUSH = 1'b1;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_kind_i == KIND_FLUSH) begin
            if (status_i.pend_nz) begin
              state_d = S_FLUSH;
            end
          end else if (status_i.divisor_zero) begin
            state_d = S_ERR;
          end else begin
            cmd_o.div_start = 1'b1;
            state_d         = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (status_i.div_done) begin
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = S_CHECK;
      end
      S_CHECK: begin
        if (status_i.bad) begin
          state_d = S_ERR;
        end else begin
          cmd_o.check = 1'b1;
          state_d     = S_ONES;
        end
      end
      S_ONES: begin
        cmd_o.app_ones = 1'b1;
        state_d        = S_WORD_O;
      end
      S_WORD_O: begin
        if (!status_i.word_full || status_i.out_free) begin
          cmd_o.emit_word = status_i.word_full;
          state_d         = status_i.ones_nz ? S_ONES : S_TAIL;
        end
      end
      S_TAIL: begin
        cmd_o.app_tail = 1'b1;
        state_d        = S_WORD_T;
      end
      S_WORD_T: begin
        if (!status_i.word_full || status_i.out_free) begin
          cmd_o.emit_word = status_i.word_full;
          state_d         = S_IDLE;
        end
      end
      S_FLUSH: begin
        if (status_i.out_free) begin
          cmd_o.emit_flush = 1'b1;
          state_d          = S_IDLE;
        end
      end
      S_ERR: begin
        if (status_i.out_free) begin
          cmd_o.emit_err = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/golomb_encoder_bit_packer_top.sv =====
// Top level of the Golomb encoder and 32-bit bit packer.
// Depends on gebp_pkg, gebp_ctrl, gebp_datapath and gebp_divider.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+--------------------------------------
//  input    | in_valid_i / in_ready_o | in_kind_i, in_value_i
//  result   | out_valid_o/out_ready_i | out_code_word_o, out_bit_count_o,
//           |                         | out_last_o, out_error_o
//  config   | cfg_we_i                | cfg_idx_i, cfg_wdata_i
//
// A value item passes through the restoring divider (one quotient bit per
// cycle), a prep and a check state, then one append and one word check per
// 32-bit chunk of unary code (at least one), then the stop bit and remainder
// field and a last word check. A flush emits the pending bits, if there are
// any; a rejected value goes to the error state at once with a zero divisor
// and after the divider, prep and check states otherwise.
// Reset is asynchronous; no clearing pass is needed.
// A stalled result holds the controller in its word, flush or error state;
// the next item is taken once the previous one has handed its last word to
// the output register.
`default_nettype none

module golomb_encoder_bit_packer_top #(
  parameter int VALUE_BITS   = 16,
  parameter int MAX_QUOTIENT = 62
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // configuration
  input  wire logic                   cfg_we_i,
  input  wire logic                   cfg_idx_i,
  input  wire logic [15:0]            cfg_wdata_i,
  // input items
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic                   in_kind_i,
  input  wire logic [VALUE_BITS-1:0]  in_value_i,
  // results
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [31:0]                 out_code_word_o,
  output logic [5:0]                  out_bit_count_o,
  output logic                        out_last_o,
  output logic                        out_error_o
);

  gebp_pkg::gebp_cmd_t    cmd;
  gebp_pkg::gebp_status_t status;

  gebp_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_kind_i (in_kind_i),
    .in_ready_o(in_ready_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  gebp_datapath #(
    .VALUE_BITS  (VALUE_BITS),
    .MAX_QUOTIENT(MAX_QUOTIENT)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .value_i        (in_value_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .out_code_word_o(out_code_word_o),
    .out_bit_count_o(out_bit_count_o),
    .out_last_o     (out_last_o),
    .out_error_o    (out_error_o)
  );

endmodule

`default_nettype wire

// ===== dv/gebp_tb_pkg.sv =====
// Testbench types for the Golomb encoder and bit packer.
// Shared by gebp_code_checker and tb_top; no other dependencies.
`timescale 1ns / 1ps

package gebp_tb_pkg;

  // Item kinds on the input channel
  typedef enum logic {
    KIND_VALUE = 1'b0,
    KIND_FLUSH = 1'b1
  } item_kind_e;

  // One result transfer as seen on the output channel
  typedef struct packed {
    logic [31:0] word;
    logic [5:0]  nbits;
    logic        last;
    logic        err;
  } code_result_t;

endpackage

// ===== dv/gebp_code_checker.sv =====
// Predicts the packed Golomb code words from the transfers on the input and config
// ports and compares them with the result channel. Depends on gebp_pkg and gebp_tb_pkg.
`timescale 1ns / 1ps

module gebp_code_checker
  import gebp_pkg::*;
  import gebp_tb_pkg::*;
#(
  parameter int VALUE_BITS   = 16,
  parameter int MAX_QUOTIENT = 62
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [15:0]           cfg_wdata_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_o,
  input  logic                  in_kind_i,
  input  logic [VALUE_BITS-1:0] in_value_i,
  input  logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  logic [31:0]           out_code_word_o,
  input  logic [5:0]            out_bit_count_o,
  input  logic                  out_last_o,
  input  logic                  out_error_o,
  output int                    fail_count_o,
  output int                    owed_count_o
);

  localparam logic [15:0] DIVISOR_RST   = 16'd8;
  localparam logic [4:0]  CODE_BITS_RST = 5'd3;

  // Shadow registers and the bit accumulator
  logic [15:0]  div_reg;
  logic [4:0]   cb_reg;
  logic [63:0]  acc_bits;
  int unsigned  acc_cnt;
  code_result_t owed_words[$];

  initial fail_count_o = 0;

  task automatic flag_mismatch(input string msg);
    fail_count_o++;
    $display("[%0t] ERROR: %s", $realtime, msg);
  endtask

  // Append n bits (0..32) and move out a full word when one is ready
  task automatic pack_bits(input logic [63:0] data, input int unsigned n);
    int unsigned rest;
    if (n == 0) return;
    data     = data & ((64'd1 << n) - 64'd1);
    acc_bits = (acc_bits << n) | data;
    acc_cnt  = acc_cnt + n;
    if (acc_cnt >= WORD_W) begin
      rest = acc_cnt - WORD_W;
      owed_words.push_back('{word: 32'(acc_bits >> rest), nbits: 6'(WORD_W),
                             last: 1'b0, err: 1'b0});
      acc_cnt  = rest;
      acc_bits = acc_bits & ((64'd1 << rest) - 64'd1);
    end
  endtask

  // Unary quotient, stop bit, truncated binary remainder
  task automatic encode_value(input logic [VALUE_BITS-1:0] val);
    int unsigned b, q, r, thr, tlen, ones, k, first;
    int          t;
    logic        bad;
    logic [63:0] tval;
    first = owed_words.size();
    b     = (cb_reg > CB_MAX) ? CB_MAX : cb_reg;
    bad   = (div_reg == '0);
    q     = 0;
    r     = 0;
    tlen  = 0;
    tval  = '0;
    if (!bad) begin
      t   = (1 << b) - int'(div_reg);
      thr = (t > 0) ? t : 0;
      q   = val / div_reg;
      r   = val % div_reg;
      if (r < thr) begin
        tlen = b - 1;
        tval = 64'(r);
      end else begin
        tlen = b;
        tval = 64'(r + thr);
      end
      bad = (q > MAX_QUOTIENT) || (acc_cnt + q + 1 + tlen >= CODE_LIMIT);
    end
    if (bad) begin
      owed_words.push_back('{word: '0, nbits: '0, last: 1'b1, err: 1'b1});
    end else begin
      ones = q;
      while (ones > 0) begin
        k = (ones > 32) ? 32 : ones;
        pack_bits((64'd1 << k) - 64'd1, k);
        ones = ones - k;
      end
      pack_bits(64'd0, 1);
      pack_bits(tval, tlen);
      if (owed_words.size() > first) owed_words[owed_words.size()-1].last = 1'b1;
    end
  endtask

  // Leftover bits, left-aligned and zero padded
  task automatic golomb_flush();
    if (acc_cnt > 0) begin
      owed_words.push_back('{word: 32'(acc_bits << (WORD_W - acc_cnt)), nbits: 6'(acc_cnt),
                             last: 1'b1, err: 1'b0});
      acc_bits = '0;
      acc_cnt  = 0;
    end
  endtask

  task automatic check_result();
    code_result_t got, want;
    got = '{word: out_code_word_o, nbits: out_bit_count_o,
            last: out_last_o, err: out_error_o};
    if (owed_words.size() == 0) begin
      flag_mismatch($sformatf("unexpected result word=%h bits=%0d last=%b err=%b",
                              got.word, got.nbits, got.last, got.err));
    end else begin
      want = owed_words.pop_front();
      if (got !== want)
        flag_mismatch($sformatf("got word=%h bits=%0d last=%b err=%b, want %h/%0d/%b/%b",
                                got.word, got.nbits, got.last, got.err,
                                want.word, want.nbits, want.last, want.err));
    end
  endtask

  // Sample every port at the rising edge; results before new items
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_reg  = DIVISOR_RST;
      cb_reg   = CODE_BITS_RST;
      acc_bits = '0;
      acc_cnt  = 0;
      owed_words.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_DIVISOR) div_reg = cfg_wdata_i;
        else                          cb_reg  = cfg_wdata_i[4:0];
      end
      if (out_valid_o && out_ready_i) check_result();
      if (in_valid_i && in_ready_o) begin
        if (in_kind_i == KIND_FLUSH) golomb_flush();
        else                         encode_value(in_value_i);
      end
    end
    owed_count_o = owed_words.size();
  end

endmodule

// ===== dv/tb_top.sv =====
// Stimulus and verdict for golomb_encoder_bit_packer_top.
// Depends on gebp_pkg, gebp_tb_pkg, gebp_code_checker and the block's RTL.
`timescale 1ns / 1ps

module tb_top;
  import gebp_pkg::*;
  import gebp_tb_pkg::*;

  localparam int VALUE_BITS   = 16;
  localparam int MAX_QUOTIENT = 62;
  localparam int CLK_PERIOD   = 10;
  localparam int SETTLE_CYC   = 40;   // idle wait after the block drains
  localparam int HOLD_CYC     = 300;
  localparam int PHASES       = 9;
  localparam int PHASE_ITEMS  = 11;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic                  cfg_idx_i;
  logic [15:0]           cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic                  in_kind_i;
  logic [VALUE_BITS-1:0] in_value_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [31:0]           out_code_word_o;
  logic [5:0]            out_bit_count_o;
  logic                  out_last_o;
  logic                  out_error_o;
  int                    fail_count;
  int                    owed_count;

  // Stimulus state shared with the receiver process
  int unsigned cur_div = 8;
  bit          calm = 1'b0;
  bit          squeeze_due = 1'b0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  golomb_encoder_bit_packer_top #(
    .VALUE_BITS  (VALUE_BITS),
    .MAX_QUOTIENT(MAX_QUOTIENT)
  ) dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .in_kind_i, .in_value_i,
    .out_valid_o, .out_ready_i, .out_code_word_o, .out_bit_count_o,
    .out_last_o, .out_error_o
  );

  gebp_code_checker #(
    .VALUE_BITS  (VALUE_BITS),
    .MAX_QUOTIENT(MAX_QUOTIENT)
  ) u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .in_kind_i, .in_value_i,
    .out_valid_o, .out_ready_i, .out_code_word_o, .out_bit_count_o,
    .out_last_o, .out_error_o,
    .fail_count_o(fail_count),
    .owed_count_o(owed_count)
  );

  // Called at a falling edge; returns at the falling edge after the transfer
  task automatic send_item(input item_kind_e kind, input logic [VALUE_BITS-1:0] val);
    int unsigned gap;
    gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_kind_i  <= kind;
    in_value_i <= val;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // Mostly codes that fit, some raw values (often rejected) and flushes
  task automatic send_random_item();
    int unsigned pick, q, v;
    pick = $urandom_range(0, 19);
    if (pick < 3) begin
      send_item(KIND_FLUSH, VALUE_BITS'($urandom));
    end else if (pick < 5 || cur_div == 0) begin
      send_item(KIND_VALUE, VALUE_BITS'($urandom));
    end else begin
      q = $urandom_range(0, 1) ? $urandom_range(0, 8) : $urandom_range(0, MAX_QUOTIENT);
      v = q * cur_div + $urandom_range(0, cur_div - 1);
      if (v > 16'hFFFF) v = $urandom_range(0, cur_div - 1);
      send_item(KIND_VALUE, VALUE_BITS'(v));
    end
  endtask

  // Waits for the block to drain, then writes both registers
  task automatic write_setting(input int unsigned m, input int unsigned b);
    logic [15:0] cb_word;
    in_valid_i <= 1'b0;
    while (owed_count != 0) @(negedge clk_i);
    repeat (SETTLE_CYC) @(negedge clk_i);
    cb_word = 16'(b);
    if ($urandom_range(0, 1)) cb_word[15:5] = 11'($urandom);   // unused bits
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_DIVISOR;
    cfg_wdata_i <= 16'(m);
    @(negedge clk_i);
    cfg_idx_i   <= CFG_CODE_BITS;
    cfg_wdata_i <= cb_word;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_div = m;
  endtask

  // Receiver: random stalls, one long hold-off on request, none when calm
  initial begin
    bit squeezed;
    squeezed    = 1'b0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (squeeze_due && !squeezed) begin
        squeezed = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYC) @(negedge clk_i);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  // Stimulus
  initial begin
    int unsigned m, b;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_DIVISOR;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    in_kind_i   = KIND_VALUE;
    in_value_i  = '0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset setting M = 8, b = 3
    send_item(KIND_FLUSH, 16'hFFFF);   // nothing pending, no result
    send_item(KIND_VALUE, 16'd0);      // completes no word
    send_item(KIND_VALUE, 16'd503);    // largest quotient, two words
    send_item(KIND_VALUE, 16'd504);    // quotient just over the bound
    send_item(KIND_VALUE, 16'hFFFF);
    send_item(KIND_VALUE, 16'd9);
    send_item(KIND_FLUSH, 16'd0);
    // Truncated binary, short and long remainder forms
    write_setting(5, 3);
    send_item(KIND_VALUE, 16'd2);
    send_item(KIND_VALUE, 16'd3);
    send_item(KIND_VALUE, 16'd4);
    send_item(KIND_VALUE, 16'd0);
    send_item(KIND_FLUSH, 16'd0);
    // Zero divisor rejects every value
    write_setting(0, 3);
    send_item(KIND_VALUE, 16'd0);
    send_item(KIND_VALUE, 16'hFFFF);
    send_item(KIND_FLUSH, 16'd0);
    // b below ceil(log2 M): negative threshold, long form masked
    write_setting(7, 1);
    send_item(KIND_VALUE, 16'd12);
    send_item(KIND_VALUE, 16'd6);
    send_item(KIND_FLUSH, 16'd0);
    // b above 16 saturates
    write_setting(1000, 31);
    send_item(KIND_VALUE, 16'd62999);
    send_item(KIND_VALUE, 16'd999);
    send_item(KIND_FLUSH, 16'd0);

    // Random phases, one setting each
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin m = 1;     b = 0;  end
        1: begin m = 65535; b = 16; end
        2: begin m = 3;     b = 2;  end
        3: begin m = 100;   b = 7;  end
        4: begin m = 0;     b = $urandom_range(0, 31); end
        5: begin m = 300;   b = 20; end
        6: begin m = 1;     b = 1;  end
        7: begin m = 40;    b = 3;  end
        default: begin
          m = $urandom_range(2, 2000);
          b = $clog2(m);
        end
      endcase
      write_setting(m, b);
      if (ph == 2) squeeze_due = 1'b1;   // long codes fill the block during the hold
      if (ph == PHASES - 1) calm = 1'b1;
      repeat (PHASE_ITEMS) send_random_item();
    end

    in_valid_i <= 1'b0;
    while (owed_count != 0) @(negedge clk_i);
    repeat (SETTLE_CYC) @(negedge clk_i);
    if (fail_count == 0)
      $display("golomb_encoder_bit_packer_top: match");
    else
      $display("golomb_encoder_bit_packer_top: mismatch");
    $finish;
  end

  // Watchdog
  initial begin
    #1_000_000;
    $display("golomb_encoder_bit_packer_top: mismatch");
    $finish;
  end

endmodule
